@@ sv/ptsb_pkg.sv @@
package ptsb_pkg;

   // Bank geometry.
   localparam int SLOT_COUNT  = 8;
   localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int COUNT_W     = $clog2(SLOT_COUNT + 1);

   // Field and datapath widths.
   localparam int TICK_W      = 20;
   localparam int PERIOD_W    = 26;
   localparam int CD_W        = 27;
   localparam int MASK_W      = 8;
   localparam int MSEC_W      = 32;
   localparam int HANDLE_W    = 16;
   localparam int MS_W        = 16;
   localparam int ACTIVE_W    = 4;

   // Time constants.
   localparam logic [TICK_W-1:0] TICK_RESET_US = 20'd54925;
   localparam int US_PER_MS = 1000;

   // Microseconds to milliseconds by reciprocal multiplication.
   // Exact for every 20-bit tick period.
   localparam int MS_RECIP_SHIFT = 30;
   localparam longint MS_RECIP_VAL =
      ((longint'(1) << MS_RECIP_SHIFT) + US_PER_MS - 1) / US_PER_MS;
   localparam int MS_RECIP_W = 21;
   localparam logic [MS_RECIP_W-1:0] MS_RECIP = MS_RECIP_W'(MS_RECIP_VAL);
   localparam int TICK_MS_W = TICK_W + MS_RECIP_W - MS_RECIP_SHIFT;
   localparam logic [TICK_MS_W-1:0] TICK_MS_RESET =
      TICK_MS_W'(TICK_RESET_US / US_PER_MS);

   // Request opcodes.
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_CREATE  = 3'd1;
   localparam logic [2:0] OP_KILL    = 3'd2;
   localparam logic [2:0] OP_ENABLE  = 3'd3;
   localparam logic [2:0] OP_DISABLE = 3'd4;
   localparam logic [2:0] OP_READ    = 3'd5;

   typedef struct packed {
      logic [2:0]          opcode;
      logic [MS_W-1:0]     period_ms;
      logic [HANDLE_W-1:0] slot_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] result_value;
      logic [MASK_W-1:0]   expired_mask;
      logic [MSEC_W-1:0]   msec_count;
      logic [ACTIVE_W-1:0] active_slots;
   } rsp_type;

endpackage

@@ sv/ptsb_slot_alu.sv @@
module ptsb_slot_alu (
   input  logic signed [ptsb_pkg::CD_W-1:0]     countdown,
   input  logic        [ptsb_pkg::PERIOD_W-1:0] period,
   input  logic        [ptsb_pkg::TICK_W-1:0]   tick_us,
   output logic signed [ptsb_pkg::CD_W-1:0]     countdown_next,
   output logic                                 expired
);

   localparam int EXT_W = ptsb_pkg::CD_W + 1;
   localparam logic signed [EXT_W-1:0] CD_MIN =
      -(EXT_W'(1) <<< (ptsb_pkg::CD_W - 1));

   logic signed [EXT_W-1:0] after_tick;
   logic signed [EXT_W-1:0] after_reload;

   // Subtract one tick, reload on zero or below, then saturate low.
   always_comb begin
      after_tick = EXT_W'(countdown) - $signed(EXT_W'(tick_us));
      expired = (after_tick <= 0);
      after_reload = expired
         ? after_tick + $signed(EXT_W'(period))
         : after_tick;
      if (after_reload < CD_MIN) begin
         countdown_next = ptsb_pkg::CD_W'(CD_MIN);
      end else begin
         countdown_next = ptsb_pkg::CD_W'(after_reload);
      end
   end

endmodule

@@ sv/ptsb_csr.sv @@
module ptsb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ptsb_pkg::TICK_W-1:0]      csr_data,
   output logic [ptsb_pkg::TICK_W-1:0]      tick_us,
   output logic [ptsb_pkg::TICK_MS_W-1:0]   tick_ms
);

   localparam int PROD_W = ptsb_pkg::TICK_W + ptsb_pkg::MS_RECIP_W;

   logic [ptsb_pkg::TICK_W-1:0]    tick_us_ff;
   logic [ptsb_pkg::TICK_MS_W-1:0] tick_ms_ff;
   logic [PROD_W-1:0]              recip_prod;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Whole milliseconds per tick, registered from the microsecond register.
   assign recip_prod = PROD_W'(tick_us_ff) * PROD_W'(ptsb_pkg::MS_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_us_ff <= ptsb_pkg::TICK_RESET_US;
         tick_ms_ff <= ptsb_pkg::TICK_MS_RESET;
      end else begin
         if (csr_valid) begin
            tick_us_ff <= csr_data;
         end
         tick_ms_ff <= recip_prod[PROD_W-1:ptsb_pkg::MS_RECIP_SHIFT];
      end
   end

   assign tick_us = tick_us_ff;
   assign tick_ms = tick_ms_ff;

endmodule

@@ sv/periodic_timer_slot_bank_core.sv @@
// Periodic timer slot bank: 8 countdown slots driven by tick requests.
// One request beat is handled at a time and gives exactly one response
// beat. A counting tick runs a single countdown unit over the slots one
// per cycle and holds the block until every slot is swept; a create
// passes an extra state as its period product is registered first, and
// every other opcode goes from execute to done. A finished response waits
// in an output register, and the block takes requests again once that
// register is free. The tick period register resets to 54925 us; it is to
// be written only while the block is idle; the block does not enforce it.
module periodic_timer_slot_bank_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ptsb_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ptsb_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ptsb_pkg::TICK_W-1:0]   csr_data
);

   localparam int SLOTS = ptsb_pkg::SLOT_COUNT;
   localparam int IDX_W = ptsb_pkg::SLOT_IDX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CREATE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   ptsb_pkg::req_type                  req_ff, req_in;
   logic [SLOTS-1:0]                   in_use_ff, in_use_in;
   logic [ptsb_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                               disabled_ff, disabled_in;
   logic [ptsb_pkg::MSEC_W-1:0]        msec_ff, msec_in;
   logic [IDX_W-1:0]                   idx_ff, idx_in;
   logic [ptsb_pkg::MASK_W-1:0]        mask_ff, mask_in;
   logic [ptsb_pkg::HANDLE_W-1:0]      result_ff, result_in;
   logic [ptsb_pkg::PERIOD_W-1:0]      prod_ff, prod_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ptsb_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic [ptsb_pkg::PERIOD_W-1:0]      period_ff [SLOTS];
   logic signed [ptsb_pkg::CD_W-1:0]   countdown_ff [SLOTS];

   logic [ptsb_pkg::TICK_W-1:0]        tick_us;
   logic [ptsb_pkg::TICK_MS_W-1:0]     tick_ms;
   logic signed [ptsb_pkg::CD_W-1:0]   alu_countdown;
   logic                               alu_expired;

   logic                               free_found;
   logic [IDX_W-1:0]                   free_idx;
   logic [IDX_W-1:0]                   kill_idx;
   logic                               kill_ok;
   logic [ptsb_pkg::PERIOD_W-1:0]      new_period;

   logic                               period_wr;
   logic                               cd_wr;
   logic [IDX_W-1:0]                   wr_idx;
   logic signed [ptsb_pkg::CD_W-1:0]   cd_wr_value;

   ptsb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .tick_us   (tick_us),
      .tick_ms   (tick_ms)
   );

   // Shared countdown unit, pointed at one slot per sweep cycle.
   ptsb_slot_alu u_alu (
      .countdown      (countdown_ff[idx_ff]),
      .period         (period_ff[idx_ff]),
      .tick_us        (tick_us),
      .countdown_next (alu_countdown),
      .expired        (alu_expired)
   );

   // Lowest free slot for create.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Kill handle check.
   assign kill_idx = IDX_W'(req_ff.slot_handle - ptsb_pkg::HANDLE_W'(1));
   assign kill_ok  = (req_ff.slot_handle != '0)
                  && (req_ff.slot_handle <= ptsb_pkg::HANDLE_W'(SLOTS))
                  && in_use_ff[kill_idx];

   // A new slot period is never shorter than one tick.
   assign new_period = (prod_ff < ptsb_pkg::PERIOD_W'(tick_us))
                     ? ptsb_pkg::PERIOD_W'(tick_us) : prod_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      in_use_in    = in_use_ff;
      count_in     = count_ff;
      disabled_in  = disabled_ff;
      msec_in      = msec_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      result_in    = result_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      period_wr    = 1'b0;
      cd_wr        = 1'b0;
      wr_idx       = idx_ff;
      cd_wr_value  = alu_countdown;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               mask_in   = '0;
               result_in = '0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (req_ff.opcode)
               ptsb_pkg::OP_TICK: begin
                  if (count_ff != '0 && !disabled_ff) begin
                     msec_in  = msec_ff + ptsb_pkg::MSEC_W'(tick_ms);
                     idx_in   = '0;
                     state_in = ST_SWEEP;
                  end
               end
               ptsb_pkg::OP_CREATE: begin
                  prod_in  = ptsb_pkg::PERIOD_W'(req_ff.period_ms)
                           * ptsb_pkg::PERIOD_W'(ptsb_pkg::US_PER_MS);
                  state_in = ST_CREATE;
               end
               ptsb_pkg::OP_KILL: begin
                  if (kill_ok) begin
                     in_use_in[kill_idx] = 1'b0;
                     count_in = count_ff - ptsb_pkg::COUNT_W'(1);
                  end else begin
                     result_in = req_ff.slot_handle;
                  end
               end
               ptsb_pkg::OP_ENABLE:  disabled_in = 1'b0;
               ptsb_pkg::OP_DISABLE: disabled_in = 1'b1;
               default: ;
            endcase
         end
         ST_CREATE: begin
            if (free_found) begin
               period_wr   = 1'b1;
               cd_wr       = 1'b1;
               wr_idx      = free_idx;
               cd_wr_value = $signed({1'b0, new_period});
               in_use_in[free_idx] = 1'b1;
               count_in  = count_ff + ptsb_pkg::COUNT_W'(1);
               result_in = ptsb_pkg::HANDLE_W'(free_idx) + ptsb_pkg::HANDLE_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            if (in_use_ff[idx_ff]) begin
               cd_wr = 1'b1;
               if (alu_expired) begin
                  mask_in = mask_ff | (ptsb_pkg::MASK_W'(1) << idx_ff);
               end
            end
            if (idx_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.result_value = result_ff;
               rsp_data_in.expired_mask = mask_ff;
               rsp_data_in.msec_count   = msec_ff;
               rsp_data_in.active_slots = ptsb_pkg::ACTIVE_W'(count_ff);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         count_ff     <= '0;
         disabled_ff  <= 1'b0;
         msec_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         count_ff     <= count_in;
         disabled_ff  <= disabled_in;
         msec_ff      <= msec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      mask_ff     <= mask_in;
      result_ff   <= result_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot period and countdown storage.
   always_ff @(posedge clock) begin
      if (period_wr) begin
         period_ff[wr_idx] <= new_period;
      end
      if (cd_wr) begin
         countdown_ff[wr_idx] <= cd_wr_value;
      end
   end

endmodule

@@ sv/ptsb_checker.sv @@
module ptsb_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  ptsb_pkg::rsp_type             rsp_data
);

   // A stalled response beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // The block is not ready again in the cycle after it takes a request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // The active count never exceeds the bank size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.active_slots <= ptsb_pkg::ACTIVE_W'(ptsb_pkg::SLOT_COUNT))
      else $error("active slot count out of range");

   // Expiry bits come only from ticks, which carry a zero result value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.expired_mask != '0 |-> rsp_data.result_value == '0)
      else $error("expired mask on a non-tick response");

endmodule

bind periodic_timer_slot_bank_core ptsb_checker u_ptsb_checker (.*);
